FILE: rtl/core/mlpi_pkg.sv
package mlpi_pkg;

  localparam int HIDDEN_NODES_DEF = 4;
  localparam int WEIGHT_DEPTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 12;

  // weight index width: covers the layout (up to 5H+2) and the store depth
  localparam int IXW = 8;

  typedef enum logic {
    OP_INFER = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_WHITE_L = 2'd0,
    REG_BLACK_L = 2'd1,
    REG_WHITE_R = 2'd2,
    REG_BLACK_R = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // sigmoid(k/2) in Q0.16, k = 0..16
  function automatic logic [15:0] sig_val(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/mlpi_div.sv
module mlpi_div #(
  parameter int FRAC_BITS = mlpi_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [7:0]            num,
  input  logic [7:0]            den,
  output logic [8+FRAC_BITS-1:0] quot,
  output mlpi_pkg::div_stat_t   stat
);

  localparam int QW = 8 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [7:0]    den_r, den_nxt;
  logic [8:0]    trial;
  logic          ge;

  assign trial = {rem_r, dvd_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW);
      dvd_nxt  = QW'(num) << FRAC_BITS;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? 8'(trial - {1'b0, den_r}) : trial[7:0];
      dvd_nxt = {dvd_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quot      = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/core/mlp_inference_two_layer_unit.sv
// Two-input perceptron, one sigmoid hidden layer of HIDDEN_NODES nodes and two
// sigmoid outputs scaled to motor drives 0..99. A load request (op=1) writes one
// signed Q.FRAC_BITS weight or bias. An infer request runs on one shared 17x17
// multiplier and a bit-serial divider: two normalising divisions, then the
// hidden nodes one by one, then the two output nodes, then the hand-over.
// in_ready is low throughout. Calibration writes are taken at any time but
// must only be issued while idle.
module mlp_inference_two_layer_unit #(
  parameter int HIDDEN_NODES = mlpi_pkg::HIDDEN_NODES_DEF,
  parameter int WEIGHT_DEPTH = mlpi_pkg::WEIGHT_DEPTH_DEF,
  parameter int FRAC_BITS    = mlpi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_left_sample,
  input  logic [7:0]         in_right_sample,
  input  logic [4:0]         in_weight_index,
  input  logic signed [15:0] in_weight_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_left_drive,
  output logic [6:0]         out_right_drive,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int IXW   = mlpi_pkg::IXW;
  localparam int AW    = $clog2(WEIGHT_DEPTH);
  localparam int CW    = $clog2(HIDDEN_NODES + 3);
  localparam int HW    = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;
  localparam int QW    = 8 + FRAC_BITS;
  localparam int ACC_W = 33 + $clog2(HIDDEN_NODES + 2);
  localparam int RW    = FRAC_BITS - 1;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_DIV_ST  = 13'b0000000000010,
    ST_DIV_WT  = 13'b0000000000100,
    ST_BIAS_RD = 13'b0000000001000,
    ST_BIAS_LD = 13'b0000000010000,
    ST_TERM_RD = 13'b0000000100000,
    ST_TERM_MU = 13'b0000001000000,
    ST_TERM_AC = 13'b0000010000000,
    ST_SIG_SP  = 13'b0000100000000,
    ST_SIG_MU  = 13'b0001000000000,
    ST_SIG_AD  = 13'b0010000000000,
    ST_ACT     = 13'b0100000000000,
    ST_OUT     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0] wl_r, bl_r, wr_r, br_r;
  logic [7:0] ls_r, rs_r;

  logic                side_r, side_nxt;
  logic signed [15:0]  xin_r [2];
  logic signed [15:0]  hid_r [HIDDEN_NODES];
  logic [CW-1:0]       node_r, node_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [IXW-1:0]      base_r, base_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [33:0]  prod_r;
  logic                neg_r, big_r, dneg_r;
  logic [15:0]         y0_r, diff_r, y_r;
  logic [RW-1:0]       r_r;
  logic [6:0]          dl_r;
  logic                out_valid_r;
  logic [6:0]          out_l_r, out_r_r;

  // weight store
  logic signed [15:0] wmem [WEIGHT_DEPTH];
  logic signed [15:0] rdata_r;
  logic               oor_r;
  logic [IXW-1:0]     raddr, waddr;
  logic               we;

  // divider
  logic                div_start;
  logic [7:0]          div_num, div_den;
  logic [QW-1:0]       div_q;
  mlpi_pkg::div_stat_t dst;

  logic               is_out;
  logic signed [8:0]  dn, dd;
  logic signed [15:0] qsat, weff, opnd;
  logic signed [16:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] shv;
  logic signed [15:0] net;
  logic [16:0]        mag, sv;
  logic [16:0]        ysum, yfin;
  logic [15:0]        ypos, act;
  logic               in_acc;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign is_out    = (node_r >= CW'(HIDDEN_NODES));

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= 8'd0;
      bl_r <= 8'd255;
      wr_r <= 8'd0;
      br_r <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mlpi_pkg::reg_idx_t'(cfg_index))
        mlpi_pkg::REG_WHITE_L: wl_r <= cfg_data;
        mlpi_pkg::REG_BLACK_L: bl_r <= cfg_data;
        mlpi_pkg::REG_WHITE_R: wr_r <= cfg_data;
        mlpi_pkg::REG_BLACK_R: br_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight store, registered read
  assign waddr = IXW'(in_weight_index);
  assign we    = in_acc && (in_op == mlpi_pkg::OP_LOAD) && (waddr < IXW'(WEIGHT_DEPTH));
  assign raddr = base_r + ((state_r == ST_BIAS_RD) ?
                 (is_out ? IXW'(HIDDEN_NODES) : IXW'(2)) : IXW'(k_r));

  always_ff @(posedge clk) begin
    if (we) begin
      wmem[waddr[AW-1:0]] <= in_weight_value;
    end
    rdata_r <= wmem[raddr[AW-1:0]];
    oor_r   <= raddr >= IXW'(WEIGHT_DEPTH);
  end

  assign weff = oor_r ? 16'sd0 : rdata_r;

  // normalisation
  assign dn = side_r ? ($signed({1'b0, rs_r}) - $signed({1'b0, wr_r}))
                     : ($signed({1'b0, ls_r}) - $signed({1'b0, wl_r}));
  assign dd = side_r ? ($signed({1'b0, br_r}) - $signed({1'b0, wr_r}))
                     : ($signed({1'b0, bl_r}) - $signed({1'b0, wl_r}));
  assign div_num   = dn[8] ? 8'(-dn) : dn[7:0];
  assign div_den   = dd[8] ? 8'(-dd) : dd[7:0];
  assign div_start = (state_r == ST_DIV_ST) && (dd != 9'sd0);

  mlpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .stat  (dst)
  );

  always_comb begin
    if (dneg_r) begin
      qsat = (div_q >= QW'(32768)) ? -16'sd32768 : -$signed(16'(div_q));
    end else begin
      qsat = (div_q > QW'(32767)) ? 16'sd32767 : $signed(16'(div_q));
    end
  end

  // shared multiplier operands
  assign opnd = is_out ? hid_r[k_r[HW-1:0]] : xin_r[k_r[0]];

  always_comb begin
    mul_a = 17'(weff);
    mul_b = 17'(opnd);
    case (state_r)
      ST_SIG_MU: begin
        mul_a = $signed({1'b0, diff_r});
        mul_b = $signed(17'(r_r));
      end
      ST_ACT, ST_OUT: begin
        mul_a = $signed({1'b0, y_r});
        mul_b = 17'sd100;
      end
      default: ;
    endcase
  end

  // sigmoid split
  assign shv = acc_r >>> FRAC_BITS;
  assign net = (shv > ACC_W'(32767)) ? 16'sd32767 :
               (shv < -ACC_W'(32768)) ? -16'sd32768 : 16'(shv);
  assign mag = net[15] ? 17'(-$signed(17'(net))) : 17'(net);
  assign sv  = mag >> RW;

  assign ysum = {1'b0, y0_r} + 17'(prod_r >>> RW);
  assign ypos = big_r ? mlpi_pkg::sig_val(5'd16) : ysum[15:0];
  assign yfin = neg_r ? (17'd65536 - {1'b0, ypos}) : {1'b0, ypos};
  assign act  = ((y_r >> (16 - FRAC_BITS)) > 16'd32767) ? 16'd32767
                                                         : (y_r >> (16 - FRAC_BITS));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    node_nxt  = node_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == mlpi_pkg::OP_INFER) begin
          state_nxt = ST_DIV_ST;
          side_nxt  = 1'b0;
          node_nxt  = '0;
          base_nxt  = '0;
        end
      end
      ST_DIV_ST: begin
        if (dd != 9'sd0) begin
          state_nxt = ST_DIV_WT;
        end else if (side_r) begin
          state_nxt = ST_BIAS_RD;
        end else begin
          side_nxt = 1'b1;
        end
      end
      ST_DIV_WT: begin
        if (dst.done) begin
          side_nxt  = 1'b1;
          state_nxt = side_r ? ST_BIAS_RD : ST_DIV_ST;
        end
      end
      ST_BIAS_RD: state_nxt = ST_BIAS_LD;
      ST_BIAS_LD: begin
        k_nxt     = '0;
        state_nxt = ST_TERM_RD;
      end
      ST_TERM_RD: state_nxt = ST_TERM_MU;
      ST_TERM_MU: state_nxt = ST_TERM_AC;
      ST_TERM_AC: begin
        k_nxt = k_r + CW'(1);
        if (k_r == (is_out ? CW'(HIDDEN_NODES - 1) : CW'(1))) begin
          state_nxt = ST_SIG_SP;
        end else begin
          state_nxt = ST_TERM_RD;
        end
      end
      ST_SIG_SP: state_nxt = ST_SIG_MU;
      ST_SIG_MU: state_nxt = ST_SIG_AD;
      ST_SIG_AD: state_nxt = ST_ACT;
      ST_ACT: begin
        node_nxt = node_r + CW'(1);
        base_nxt = base_r + (is_out ? IXW'(HIDDEN_NODES + 1) : IXW'(3));
        if (node_r == CW'(HIDDEN_NODES + 1)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_BIAS_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= 1'b0;
      node_r      <= '0;
      k_r         <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
      node_r  <= node_nxt;
      k_r     <= k_nxt;
      base_r  <= base_nxt;
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      ls_r <= in_left_sample;
      rs_r <= in_right_sample;
    end
    if (state_r == ST_DIV_ST) begin
      dneg_r <= dn[8] ^ dd[8];
      if (dd == 9'sd0) begin
        xin_r[side_r] <= (dn > 9'sd0) ? 16'sd32767 :
                         (dn < 9'sd0) ? -16'sd32768 : 16'sd0;
      end
    end
    if (state_r == ST_DIV_WT && dst.done) begin
      xin_r[side_r] <= qsat;
    end
    if (state_r == ST_BIAS_LD) begin
      acc_r <= ACC_W'(weff) <<< FRAC_BITS;
    end
    if (state_r == ST_TERM_AC) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == ST_SIG_SP) begin
      neg_r  <= net[15];
      big_r  <= sv >= 17'd16;
      y0_r   <= mlpi_pkg::sig_val(5'(sv[3:0]));
      diff_r <= mlpi_pkg::sig_val(5'(sv[3:0]) + 5'd1) - mlpi_pkg::sig_val(5'(sv[3:0]));
      r_r    <= mag[RW-1:0];
    end
    if (state_r == ST_SIG_AD) begin
      y_r <= yfin[15:0];
    end
    if (state_r == ST_ACT && !is_out) begin
      hid_r[node_r[HW-1:0]] <= $signed(act);
    end
    if (state_r == ST_BIAS_RD && node_r == CW'(HIDDEN_NODES + 1)) begin
      dl_r <= prod_r[22:16];
    end
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_l_r <= dl_r;
      out_r_r <= prod_r[22:16];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_l_r;
  assign out_right_drive = out_r_r;

  // left drive taken as the second output node starts; the right one is
  // held on prod_r throughout ST_OUT
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !dst.busy)
    else $error("divider busy while idle");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == mlpi_pkg::OP_LOAD |=> state_r == ST_IDLE)
    else $error("load request started work");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result raised outside hand-over");

endmodule

FILE: tb/tb_mlp_inference_two_layer_unit.sv
`timescale 1ns / 100ps

module tb_mlp_inference_two_layer_unit;

  localparam int NHID = 4;
  localparam int NW = 32;
  localparam int FB = 12;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic [7:0] in_left_sample = '0;
  logic [7:0] in_right_sample = '0;
  logic [4:0] in_weight_index = '0;
  logic signed [15:0] in_weight_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [6:0] out_left_drive;
  logic [6:0] out_right_drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  mlp_inference_two_layer_unit i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [6:0] left;
    logic [6:0] right;
  } drive_t;

  drive_t drive_q[$];
  logic signed [15:0] wts[NW];
  logic [7:0] cal[4];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic int sigmoid_q16(int x);
    int a, s, r, y;
    a = x < 0 ? -x : x;
    s = a >>> (FB - 1);
    r = a & ((1 << (FB - 1)) - 1);
    if (s >= 16) y = int'(mlpi_pkg::sig_val(5'd16));
    else y = int'(mlpi_pkg::sig_val(s[4:0])) +
             int'((longint'(int'(mlpi_pkg::sig_val(s[4:0] + 5'd1)) -
                            int'(mlpi_pkg::sig_val(s[4:0]))) * r) >>> (FB - 1));
    return x < 0 ? 65536 - y : y;
  endfunction

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int norm_sample(logic [7:0] smp, logic [7:0] wh, logic [7:0] bl);
    longint n, d;
    n = longint'(smp) - longint'(wh);
    d = longint'(bl) - longint'(wh);
    if (d == 0) return n > 0 ? 32767 : (n < 0 ? -32768 : 0);
    return sat16((n * (longint'(1) << FB)) / d);
  endfunction

  function automatic int net_floor(longint acc);
    return sat16(acc >>> FB);
  endfunction

  function automatic int wt(int ix);
    return ix < NW ? int'(wts[ix]) : 0;
  endfunction

  function automatic drive_t infer_drives(logic [7:0] ls, logic [7:0] rs);
    int x0, x1, act, y, b;
    int hid[NHID];
    longint acc;
    drive_t d;
    x0 = norm_sample(ls, cal[mlpi_pkg::REG_WHITE_L], cal[mlpi_pkg::REG_BLACK_L]);
    x1 = norm_sample(rs, cal[mlpi_pkg::REG_WHITE_R], cal[mlpi_pkg::REG_BLACK_R]);
    for (int h = 0; h < NHID; h++) begin
      acc = longint'(wt(3 * h + 2)) * (longint'(1) << FB)
            + longint'(wt(3 * h)) * x0 + longint'(wt(3 * h + 1)) * x1;
      act = sigmoid_q16(net_floor(acc)) >>> (16 - FB);
      hid[h] = act > 32767 ? 32767 : act;
    end
    for (int o = 0; o < 2; o++) begin
      b = 3 * NHID + (NHID + 1) * o;
      acc = longint'(wt(b + NHID)) * (longint'(1) << FB);
      for (int h = 0; h < NHID; h++) acc += longint'(wt(b + h)) * hid[h];
      y = sigmoid_q16(net_floor(acc));
      if (o == 0) d.left = 7'((y * 100) >>> 16);
      else d.right = 7'((y * 100) >>> 16);
    end
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic send_request(mlpi_pkg::op_t op, logic [7:0] ls, logic [7:0] rs,
                              logic [4:0] ix, logic signed [15:0] val);
    int gap;
    if (!stim_done && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_left_sample <= ls;
    in_right_sample <= rs;
    in_weight_index <= ix;
    in_weight_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == mlpi_pkg::OP_LOAD) wts[ix] = val;
    else drive_q.push_back(infer_drives(ls, rs));
  endtask

  task automatic stop_requests();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic load(int ix, int val);
    send_request(mlpi_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 5'(ix), 16'(val));
  endtask

  task automatic infer(logic [7:0] ls, logic [7:0] rs);
    send_request(mlpi_pkg::OP_INFER, ls, rs, 5'($urandom), 16'($urandom));
  endtask

  task automatic write_cal(mlpi_pkg::reg_idx_t ix, logic [7:0] val);
    stop_requests();
    while (drive_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cal[ix] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_cal(logic [7:0] wl, logic [7:0] bl, logic [7:0] wr, logic [7:0] br);
    write_cal(mlpi_pkg::REG_WHITE_L, wl);
    write_cal(mlpi_pkg::REG_BLACK_L, bl);
    write_cal(mlpi_pkg::REG_WHITE_R, wr);
    write_cal(mlpi_pkg::REG_BLACK_R, br);
  endtask

  function automatic int rand_weight();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return int'($urandom_range(0, 16383)) - 8192;
    endcase
  endfunction

  task automatic test_load_all();
    load(0, 32767);
    load(1, -32768);
    for (int i = 2; i < NW; i++) load(i, rand_weight());
    load(31, 16'h5555);
    load(30, 16'hAAAA);
  endtask

  task automatic test_extremes();
    infer(8'd0, 8'd0);
    infer(8'd255, 8'd255);
    infer(8'd0, 8'd255);
    infer(8'd255, 8'd0);
    infer(8'h55, 8'hAA);
  endtask

  task automatic test_zero_divisor();
    set_cal(8'd100, 8'd100, 8'd0, 8'd0);
    infer(8'd101, 8'd0);
    infer(8'd99, 8'd1);
    infer(8'd100, 8'd0);
    set_cal(8'd255, 8'd0, 8'd200, 8'd10);
    infer(8'd0, 8'd255);
    infer(8'd128, 8'd5);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) load($urandom_range(0, NW - 1), rand_weight());
      else infer(8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) infer(8'($urandom), 8'($urandom));
    hold_off = 1'b0;
  endtask

  initial begin
    cal[mlpi_pkg::REG_WHITE_L] = 8'd0;
    cal[mlpi_pkg::REG_BLACK_L] = 8'd255;
    cal[mlpi_pkg::REG_WHITE_R] = 8'd0;
    cal[mlpi_pkg::REG_BLACK_R] = 8'd255;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_load_all();
    test_extremes();
    test_zero_divisor();
    set_cal(8'd0, 8'd255, 8'd0, 8'd255);
    test_random(400);
    test_backpressure();
    set_cal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    test_random(400);
    set_cal(8'd20, 8'd230, 8'd240, 8'd15);
    test_random(200);
    stim_done = 1'b1;
    test_random(250);
    stop_requests();
    while (drive_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // receiver: bursts of stall, long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
        while (hold_off) begin
          out_ready <= 1'b1;
          @(negedge clk);
        end
      end else if (!stim_done && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    drive_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected result", out_left_drive, 0);
      end else begin
        want = drive_q.pop_front();
        if (out_left_drive !== want.left)
          report_mismatch("left_drive", out_left_drive, want.left);
        if (out_right_drive !== want.right)
          report_mismatch("right_drive", out_right_drive, want.right);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

FILE: filelist.f
rtl/core/mlpi_pkg.sv
rtl/core/mlpi_div.sv
rtl/core/mlp_inference_two_layer_unit.sv
tb/tb_mlp_inference_two_layer_unit.sv
